### src/kpt_pkg.sv
// ----------------------------------------------------------------------------
// kpt_pkg: shared types and constants for the keyed price table
// Table depth, field widths, stream packing widths and the token that walks
// down the cell chain.
// ----------------------------------------------------------------------------
package kpt_pkg;

   localparam int ENTRIES     = 64;
   localparam int FIELD_W     = 31;
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 96;

   typedef logic [FIELD_W-1:0] word_type;

   // One request in flight along the chain, with the running max and min.
   typedef struct packed {
      logic     done;
      logic     any;
      word_type stamp;
      word_type amount;
      word_type hi;
      word_type lo;
   } tok_type;

endpackage

### src/keyed_price_table_min_max.sv
// ----------------------------------------------------------------------------
// keyed_price_table_min_max: keyed price table with latest, max and min
// Keeps a table of stamp-to-amount entries as a chain of cells and answers
// each record with the latest amount and the max and min of stored amounts.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one (stamp, amount) record per request. A stored stamp
//   replaces its amount, a new stamp takes the lowest free entry, and a new
//   stamp on a full table is dropped with table_full set in its response.
//   rsp channel: one response per request, in order.
// Flow: a request walks the chain one cell per cycle while the chain is not
//   held; its response is then registered in the output register.
// Requests: one request at a time; a new request is taken only once the
//   last one has left the chain for the output register.
// Reset: all entries free, no latest amount held, both channels idle.
// Stall: a response waits in the output register while rsp_tready is low;
//   a new request is still taken and walks the chain, and it holds at the
//   last cell until the output register frees up.
// ----------------------------------------------------------------------------
module keyed_price_table_min_max
   import kpt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // stamp[30:0], amount[61:31], zero pad
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // latest_amount[30:0],
                                               // highest_amount[61:31],
                                               // lowest_amount[92:62], zero pad
   output logic                   rsp_tuser    // table_full
);

   logic     chain_valid [ENTRIES+1];
   tok_type  chain_tok   [ENTRIES+1];
   logic     advance, accept, load, full, take_latest;

   logic     busy_ff, busy_in;
   logic     rsp_valid_ff, rsp_valid_in;
   logic     have_latest_ff, have_latest_in;
   word_type latest_stamp_ff, latest_stamp_in;
   word_type latest_value_ff, latest_value_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic     rsp_full_ff, rsp_full_in;

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && req_tready;

   // hold the chain only when its last cell has a result and the output is blocked
   assign advance = !(chain_valid[ENTRIES] && rsp_valid_ff && !rsp_tready);
   assign load    = chain_valid[ENTRIES] && advance;

   always_comb begin
      chain_valid[0]      = accept;
      chain_tok[0].done   = 1'b0;
      chain_tok[0].any    = 1'b0;
      chain_tok[0].stamp  = req_tdata[FIELD_W-1:0];
      chain_tok[0].amount = req_tdata[2*FIELD_W-1:FIELD_W];
      chain_tok[0].hi     = '0;
      chain_tok[0].lo     = '0;
   end

   for (genvar i = 0; i < ENTRIES; i++) begin : gen_cell
      kpt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .prev_valid (chain_valid[i]),
         .prev_tok   (chain_tok[i]),
         .next_valid (chain_valid[i+1]),
         .next_tok   (chain_tok[i+1])
      );
   end

   always_comb begin
      full        = !chain_tok[ENTRIES].done;
      take_latest = !full && (!have_latest_ff || chain_tok[ENTRIES].stamp >= latest_stamp_ff);

      have_latest_in  = have_latest_ff;
      latest_stamp_in = latest_stamp_ff;
      latest_value_in = latest_value_ff;
      if (load && take_latest) begin
         have_latest_in  = 1'b1;
         latest_stamp_in = chain_tok[ENTRIES].stamp;
         latest_value_in = chain_tok[ENTRIES].amount;
      end

      rsp_data_in = {{(RSP_TDATA_W-3*FIELD_W){1'b0}}, chain_tok[ENTRIES].lo,
                     chain_tok[ENTRIES].hi, latest_value_in};
      rsp_full_in = full;

      if (load)
         rsp_valid_in = 1'b1;
      else if (rsp_tready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;

      if (accept)
         busy_in = 1'b1;
      else if (load)
         busy_in = 1'b0;
      else
         busy_in = busy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         have_latest_ff  <= 1'b0;
         latest_stamp_ff <= '0;
         latest_value_ff <= '0;
      end else begin
         busy_ff         <= busy_in;
         rsp_valid_ff    <= rsp_valid_in;
         have_latest_ff  <= have_latest_in;
         latest_stamp_ff <= latest_stamp_in;
         latest_value_ff <= latest_value_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_full_ff <= rsp_full_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_full_ff;

endmodule

### src/kpt_cell.sv
// ----------------------------------------------------------------------------
// kpt_cell: one table entry of the price chain
// Holds one stamp/amount pair. A passing request updates the entry on a stamp
// match or claims it when free, then folds the entry's amount into the
// running max and min before handing the request to the next cell.
// ----------------------------------------------------------------------------
module kpt_cell
   import kpt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  logic    prev_valid,
   input  tok_type prev_tok,
   output logic    next_valid,
   output tok_type next_tok
);

   logic     used_ff, used_in;
   word_type stamp_ff, stamp_in;
   word_type amount_ff, amount_in;
   logic     valid_ff, valid_in;
   tok_type  tok_ff, tok_in;
   logic     hit, take;

   always_comb begin
      hit  = prev_valid && !prev_tok.done && used_ff && (stamp_ff == prev_tok.stamp);
      take = prev_valid && !prev_tok.done && !used_ff;

      used_in   = used_ff | take;
      stamp_in  = take ? prev_tok.stamp : stamp_ff;
      amount_in = (hit || take) ? prev_tok.amount : amount_ff;

      valid_in    = prev_valid;
      tok_in      = prev_tok;
      tok_in.done = prev_tok.done | hit | take;
      // fold this entry in, using the amount it holds after the update
      if (used_in) begin
         tok_in.any = 1'b1;
         if (!prev_tok.any) begin
            tok_in.hi = amount_in;
            tok_in.lo = amount_in;
         end else begin
            if (amount_in > prev_tok.hi) tok_in.hi = amount_in;
            if (amount_in < prev_tok.lo) tok_in.lo = amount_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else if (advance) begin
         used_ff  <= used_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stamp_ff  <= stamp_in;
         amount_ff <= amount_in;
         tok_ff    <= tok_in;
      end
   end

   assign next_valid = valid_ff;
   assign next_tok   = tok_ff;

endmodule

### src/kpt_checker.sv
// ----------------------------------------------------------------------------
// kpt_checker: port-level checks for the keyed price table
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module kpt_checker
   import kpt_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tuser
);

   logic [FIELD_W-1:0] latest, highest, lowest;

   assign latest  = rsp_tdata[FIELD_W-1:0];
   assign highest = rsp_tdata[2*FIELD_W-1:FIELD_W];
   assign lowest  = rsp_tdata[3*FIELD_W-1:2*FIELD_W];

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // one request at a time in the chain
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in flight");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> lowest <= highest)
      else $error("lowest amount above highest amount");

   // the latest amount always lies between the lowest and highest stored amounts
   a_latest_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> lowest <= latest && latest <= highest)
      else $error("latest amount outside stored range");

endmodule

bind keyed_price_table_min_max kpt_checker u_kpt_checker (.*);
